[rtl/fedp_pkg.sv]
// Package with types, constants and command/status structs of the field energy density block.
package fedp_pkg;

  // Field widths.
  localparam int VAL_W     = 24;
  localparam int CFG_W     = 24;
  localparam int WIN_W     = 11;
  localparam int DENS_W    = 32;
  localparam int TOT_W     = 48;
  localparam int IDX_OUT_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TWO_H = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HI = 2'd3;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] INV_TWO_H_RST = 24'd32768;
  localparam logic [CFG_W-1:0] GRID_STEP_RST = 24'd65536;
  localparam logic [WIN_W-1:0] WINDOW_LO_RST = 11'd0;
  localparam logic [WIN_W-1:0] WINDOW_HI_RST = 11'd1024;

  // Totals, in the order they are scaled.
  localparam int TOT_SEL_W = 3;
  localparam logic [TOT_SEL_W-1:0] TOT_ENERGY    = 3'd0;
  localparam logic [TOT_SEL_W-1:0] TOT_KINETIC   = 3'd1;
  localparam logic [TOT_SEL_W-1:0] TOT_GRADIENT  = 3'd2;
  localparam logic [TOT_SEL_W-1:0] TOT_POTENTIAL = 3'd3;
  localparam logic [TOT_SEL_W-1:0] TOT_WINDOW    = 3'd4;

  // Operation of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KIN,
    MUL_SLOPE,
    MUL_GRAD,
    MUL_TOT_HI,
    MUL_TOT_LO
  } mul_op_e;

  // Which point of the current sample is being worked on.
  // PT_A: the interior point behind the sample, PT_B: the last point,
  // PT_C: point zero, closed around the periodic boundary.
  typedef enum logic [1:0] {
    PT_A,
    PT_B,
    PT_C
  } pt_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_KIN,
    ST_SLOPE,
    ST_GRAD,
    ST_ACC,
    ST_TOT_HI,
    ST_TOT_LO,
    ST_TOT_ADD,
    ST_SHOW,
    ST_END
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load;
    mul_op_e              mul_op;
    pt_e                  pt;
    logic [TOT_SEL_W-1:0] tot_sel;
    logic                 acc;
    logic                 final_pt;
    logic                 tot_write;
    logic                 show;
    logic                 item_end;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ge1;
    logic ge2;
    logic last;
    logic out_free;
  } stat_t;

endpackage

[rtl/fedp_ctrl.sv]
// Sequencing state machine of the field energy density block.
module fedp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fedp_pkg::stat_t stat_i,
  output fedp_pkg::cmd_t  cmd_o
);
  import fedp_pkg::*;

  ctrl_state_e          state_q, state_d;
  pt_e                  pt_q, pt_d;
  logic [TOT_SEL_W-1:0] tot_q, tot_d;
  logic                 final_pt;

  // A point closes the field when it is the last point of a one-sample field
  // or point zero.
  assign final_pt = ((pt_q == PT_B) && !stat_i.ge1) || (pt_q == PT_C);

  // State, point and total registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pt_q    <= PT_A;
      tot_q   <= TOT_ENERGY;
    end else begin
      state_q <= state_d;
      pt_q    <= pt_d;
      tot_q   <= tot_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d          = state_q;
    pt_d             = pt_q;
    tot_d            = tot_q;
    cmd_o            = '0;
    cmd_o.mul_op     = MUL_NONE;
    cmd_o.pt         = pt_q;
    cmd_o.tot_sel    = tot_q;
    cmd_o.final_pt   = final_pt;
    in_stall_o       = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (stat_i.ge2) begin
          pt_d    = PT_A;
          state_d = ST_KIN;
        end else if (stat_i.last) begin
          pt_d    = PT_B;
          state_d = ST_KIN;
        end else begin
          state_d = ST_END;
        end
      end
      ST_KIN: begin
        cmd_o.mul_op = MUL_KIN;
        state_d      = ST_SLOPE;
      end
      ST_SLOPE: begin
        cmd_o.mul_op = MUL_SLOPE;
        state_d      = ST_GRAD;
      end
      ST_GRAD: begin
        cmd_o.mul_op = MUL_GRAD;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        // Wait here until the output register can take the point.
        if (stat_i.out_free) begin
          cmd_o.acc = 1'b1;
          if (final_pt) begin
            tot_d   = TOT_ENERGY;
            state_d = ST_TOT_HI;
          end else if (pt_q == PT_A) begin
            if (stat_i.last) begin
              pt_d    = PT_B;
              state_d = ST_KIN;
            end else begin
              state_d = ST_END;
            end
          end else begin
            pt_d    = PT_C;
            state_d = ST_KIN;
          end
        end
      end
      ST_TOT_HI: begin
        cmd_o.mul_op = MUL_TOT_HI;
        state_d      = ST_TOT_LO;
      end
      ST_TOT_LO: begin
        cmd_o.mul_op = MUL_TOT_LO;
        state_d      = ST_TOT_ADD;
      end
      ST_TOT_ADD: begin
        cmd_o.tot_write = 1'b1;
        if (tot_q == TOT_WINDOW) begin
          state_d = ST_SHOW;
        end else begin
          tot_d   = tot_q + TOT_SEL_W'(1);
          state_d = ST_TOT_HI;
        end
      end
      ST_SHOW: begin
        cmd_o.show = 1'b1;
        state_d    = ST_END;
      end
      ST_END: begin
        cmd_o.item_end = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/fedp_dp.sv]
// Datapath of the field energy density block: sample history, shared multiplier, sums, output.
module fedp_dp #(
  parameter int GRID_POINTS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [fedp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [fedp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic signed [fedp_pkg::VAL_W-1:0]     field_value_i,
  input  logic signed [fedp_pkg::VAL_W-1:0]     field_rate_i,
  input  logic                                 last_sample_i,
  input  fedp_pkg::cmd_t                       cmd_i,
  output fedp_pkg::stat_t                      stat_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic        [fedp_pkg::IDX_OUT_W-1:0] point_index_o,
  output logic        [fedp_pkg::DENS_W-1:0]    kinetic_o,
  output logic        [fedp_pkg::DENS_W-1:0]    gradient_o,
  output logic        [fedp_pkg::DENS_W-1:0]    potential_o,
  output logic        [fedp_pkg::DENS_W-1:0]    energy_density_o,
  output logic        [fedp_pkg::TOT_W-1:0]     total_energy_o,
  output logic        [fedp_pkg::TOT_W-1:0]     total_kinetic_o,
  output logic        [fedp_pkg::TOT_W-1:0]     total_gradient_o,
  output logic        [fedp_pkg::TOT_W-1:0]     total_potential_o,
  output logic        [fedp_pkg::TOT_W-1:0]     window_energy_o,
  output logic                                 final_result_o
);
  import fedp_pkg::*;

  localparam int CW = $clog2(GRID_POINTS);
  localparam int WW = (CW > WIN_W) ? CW : WIN_W;

  // Magnitude of a signed sample; the most negative value maps to 2^23.
  function automatic logic [VAL_W-1:0] mag(input logic signed [VAL_W-1:0] x);
    logic [VAL_W-1:0] u;
    u = $unsigned(x);
    return x[VAL_W-1] ? (~u + VAL_W'(1)) : u;
  endfunction

  // Saturating add of a density into a 48-bit sum.
  function automatic logic [TOT_W-1:0] add_sat(input logic [TOT_W-1:0] s,
                                               input logic [DENS_W-1:0] x);
    logic [TOT_W:0] t;
    t = {1'b0, s} + (TOT_W + 1)'(x);
    return t[TOT_W] ? '1 : t[TOT_W-1:0];
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] inv_two_h_q, grid_step_q;
  logic [WIN_W-1:0] window_lo_q, window_hi_q;

  // Sample history.
  logic [CW-1:0]           count_q;
  logic                    last_q;
  logic signed [VAL_W-1:0] v_q, r_q;
  logic signed [VAL_W-1:0] older_q, newer_q, newer_rate_q;
  logic signed [VAL_W-1:0] first_value_q, second_value_q, first_rate_q;

  // Multiplier and intermediate results.
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [DENS_W-1:0] kin_q;
  logic [TOT_W-1:0]  tot_hi_q;

  // Sums.
  logic [TOT_W-1:0] energy_sum_q, kinetic_sum_q, gradient_sum_q, potential_sum_q;
  logic [TOT_W-1:0] window_sum_q;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [IDX_OUT_W-1:0] point_index_q;
  logic [DENS_W-1:0]    kinetic_q, gradient_q, potential_q, energy_q;
  logic [TOT_W-1:0]     tot_energy_q, tot_kinetic_q, tot_gradient_q, tot_potential_q;
  logic [TOT_W-1:0]     tot_window_q;
  logic                 final_q;

  // Point operands.
  logic [CW-1:0]           idx_sel;
  logic signed [VAL_W-1:0] left_sel, centre_sel, right_sel, rate_sel;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          diff_abs;
  logic [VAL_W-1:0]        rate_mag, diff_mag, centre_mag;
  logic [WW-1:0]           idx_w;
  logic                    in_window;

  // Density and total arithmetic.
  logic [PROD_W-18:0]  grad_full;
  logic [DENS_W-1:0]   grad_val, pot_val, en_val;
  logic [DENS_W+1:0]   en_full;
  logic [TOT_W-1:0]    tot_sum;
  logic [TOT_W+8:0]    scaled_full;
  logic [TOT_W-1:0]    scaled;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_two_h_q <= INV_TWO_H_RST;
      grid_step_q <= GRID_STEP_RST;
      window_lo_q <= WINDOW_LO_RST;
      window_hi_q <= WINDOW_HI_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INV_TWO_H: inv_two_h_q <= cfg_data_i;
        CFG_GRID_STEP: grid_step_q <= cfg_data_i;
        CFG_WINDOW_LO: window_lo_q <= cfg_data_i[WIN_W-1:0];
        CFG_WINDOW_HI: window_hi_q <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample count; an overlong field ends at the last grid index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.item_end) begin
      count_q <= last_q ? '0 : count_q + CW'(1);
    end
  end

  // Sample capture and history shift.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q    <= field_value_i;
      r_q    <= field_rate_i;
      last_q <= last_sample_i || (count_q >= CW'(GRID_POINTS - 1));
      if (count_q == '0) begin
        first_value_q  <= field_value_i;
        second_value_q <= field_value_i;
        first_rate_q   <= field_rate_i;
      end else if (count_q == CW'(1)) begin
        second_value_q <= field_value_i;
      end
    end
    if (cmd_i.item_end && !last_q) begin
      older_q      <= newer_q;
      newer_q      <= v_q;
      newer_rate_q <= r_q;
    end
  end

  // Operands of the point being worked on.
  always_comb begin
    idx_sel    = count_q - CW'(1);
    left_sel   = older_q;
    centre_sel = newer_q;
    right_sel  = v_q;
    rate_sel   = newer_rate_q;
    unique case (cmd_i.pt)
      PT_A: ;
      PT_B: begin
        idx_sel    = count_q;
        left_sel   = stat_o.ge1 ? newer_q : v_q;
        centre_sel = v_q;
        right_sel  = first_value_q;
        rate_sel   = r_q;
      end
      PT_C: begin
        idx_sel    = '0;
        left_sel   = v_q;
        centre_sel = first_value_q;
        right_sel  = second_value_q;
        rate_sel   = first_rate_q;
      end
      default: ;
    endcase
  end

  // Magnitudes; a neighbor difference always fits in 24 unsigned bits.
  assign diff       = {right_sel[VAL_W-1], right_sel} - {left_sel[VAL_W-1], left_sel};
  assign diff_abs   = diff[VAL_W] ? (~$unsigned(diff) + (VAL_W + 1)'(1)) : $unsigned(diff);
  assign diff_mag   = diff_abs[VAL_W-1:0];
  assign rate_mag   = mag(rate_sel);
  assign centre_mag = mag(centre_sel);
  assign idx_w      = WW'(idx_sel);
  assign in_window  = (idx_w >= WW'(window_lo_q)) && (idx_w < WW'(window_hi_q));

  // Select the sum being scaled.
  always_comb begin
    tot_sum = energy_sum_q;
    unique case (cmd_i.tot_sel)
      TOT_ENERGY:    tot_sum = energy_sum_q;
      TOT_KINETIC:   tot_sum = kinetic_sum_q;
      TOT_GRADIENT:  tot_sum = gradient_sum_q;
      TOT_POTENTIAL: tot_sum = potential_sum_q;
      TOT_WINDOW:    tot_sum = window_sum_q;
      default: ;
    endcase
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      MUL_NONE: ;
      MUL_KIN: begin
        mul_a = MUL_W'(rate_mag);
        mul_b = MUL_W'(rate_mag);
      end
      MUL_SLOPE: begin
        mul_a = MUL_W'(diff_mag);
        mul_b = MUL_W'(inv_two_h_q);
      end
      MUL_GRAD: begin
        // Slope in Q16.16 is the product of the previous step shifted down by 16.
        mul_a = prod_q[MUL_W+15:16];
        mul_b = prod_q[MUL_W+15:16];
      end
      MUL_TOT_HI: begin
        mul_a = MUL_W'(tot_sum[TOT_W-1:24]);
        mul_b = MUL_W'(grid_step_q);
      end
      MUL_TOT_LO: begin
        mul_a = MUL_W'(tot_sum[23:0]);
        mul_b = MUL_W'(grid_step_q);
      end
      default: ;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Product register and the values kept from earlier products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_op == MUL_SLOPE) begin
      kin_q <= prod_q[DENS_W+16:17];
    end
    if (cmd_i.mul_op == MUL_TOT_LO) begin
      tot_hi_q <= prod_q[TOT_W-1:0];
    end
  end

  // Densities of the point, from the gradient product now in the register.
  assign grad_full = prod_q[PROD_W-1:17];
  assign grad_val  = (|grad_full[PROD_W-18:DENS_W]) ? '1 : grad_full[DENS_W-1:0];
  assign pot_val   = DENS_W'(centre_mag);
  assign en_full   = (DENS_W + 2)'(kin_q) + (DENS_W + 2)'(grad_val) + (DENS_W + 2)'(pot_val);
  assign en_val    = (|en_full[DENS_W+1:DENS_W]) ? '1 : en_full[DENS_W-1:0];

  // Scaled total: high half times step shifted up by 8, plus low half times
  // step shifted down by 16.
  assign scaled_full = (TOT_W + 9)'({tot_hi_q, 8'b0}) + (TOT_W + 9)'(prod_q[TOT_W-1:16]);
  assign scaled      = (|scaled_full[TOT_W+8:TOT_W]) ? '1 : scaled_full[TOT_W-1:0];

  // Running sums, cleared when a field is done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_sum_q    <= '0;
      kinetic_sum_q   <= '0;
      gradient_sum_q  <= '0;
      potential_sum_q <= '0;
      window_sum_q    <= '0;
    end else if (cmd_i.acc) begin
      energy_sum_q    <= add_sat(energy_sum_q, en_val);
      kinetic_sum_q   <= add_sat(kinetic_sum_q, kin_q);
      gradient_sum_q  <= add_sat(gradient_sum_q, grad_val);
      potential_sum_q <= add_sat(potential_sum_q, pot_val);
      if (in_window) begin
        window_sum_q <= add_sat(window_sum_q, en_val);
      end
    end else if (cmd_i.item_end && last_q) begin
      energy_sum_q    <= '0;
      kinetic_sum_q   <= '0;
      gradient_sum_q  <= '0;
      potential_sum_q <= '0;
      window_sum_q    <= '0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      point_index_q   <= IDX_OUT_W'(idx_sel);
      kinetic_q       <= kin_q;
      gradient_q      <= grad_val;
      potential_q     <= pot_val;
      energy_q        <= en_val;
      tot_energy_q    <= '0;
      tot_kinetic_q   <= '0;
      tot_gradient_q  <= '0;
      tot_potential_q <= '0;
      tot_window_q    <= '0;
      final_q         <= 1'b0;
    end
    if (cmd_i.tot_write) begin
      unique case (cmd_i.tot_sel)
        TOT_ENERGY:    tot_energy_q    <= scaled;
        TOT_KINETIC:   tot_kinetic_q   <= scaled;
        TOT_GRADIENT:  tot_gradient_q  <= scaled;
        TOT_POTENTIAL: tot_potential_q <= scaled;
        TOT_WINDOW:    tot_window_q    <= scaled;
        default: ;
      endcase
    end
    if (cmd_i.show) begin
      final_q <= 1'b1;
    end
  end

  // Output valid: set by a finished request, cleared when it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if ((cmd_i.acc && !cmd_i.final_pt) || cmd_i.show) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Status toward the controller.
  assign stat_o.ge1      = (count_q != '0);
  assign stat_o.ge2      = (count_q >= CW'(2));
  assign stat_o.last     = last_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign point_index_o     = point_index_q;
  assign kinetic_o         = kinetic_q;
  assign gradient_o        = gradient_q;
  assign potential_o       = potential_q;
  assign energy_density_o  = energy_q;
  assign total_energy_o    = tot_energy_q;
  assign total_kinetic_o   = tot_kinetic_q;
  assign total_gradient_o  = tot_gradient_q;
  assign total_potential_o = tot_potential_q;
  assign window_energy_o   = tot_window_q;
  assign final_result_o    = final_q;

  // The closing request is only raised into an empty output register.
  a_show_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.show |-> !out_valid_q)
    else $error("closing request raised over a pending one");

  // Requests before the closing one carry zero totals.
  a_open_zero_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !final_q) |-> (tot_energy_q == '0 && tot_window_q == '0))
    else $error("non-final request carries totals");

  // The energy density never falls below its kinetic part or its potential part.
  a_energy_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (energy_q >= kinetic_q && energy_q >= potential_q))
    else $error("energy density below one of its parts");

endmodule

[rtl/field_energy_density_periodic.sv]
// Top level of the streamed energy density block on a periodic grid.
//
// Each accepted sample carries phi and d(phi)/dt of one grid point. The point
// behind it (index i-1) is reported when sample i arrives, from index two on;
// at the last sample the last point and point zero follow, the final request
// carrying the grid-step-scaled totals and final_result. One 32x32 multiplier
// is shared by all products: three dependent products per point (rate squared,
// slope, slope squared) run in ST_KIN, ST_SLOPE and ST_GRAD, and each of the
// five totals takes a high and a low product on the same multiplier before its
// add. The input stalls while a sample is worked on, so a new sample is taken
// only once the last one is done. Output stall holds the block in ST_ACC once
// the output register is full. Configuration is taken in any cycle.
module field_energy_density_periodic #(
  parameter int GRID_POINTS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [fedp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [fedp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [fedp_pkg::VAL_W-1:0]     field_value_i,
  input  logic signed [fedp_pkg::VAL_W-1:0]     field_rate_i,
  input  logic                                 last_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [fedp_pkg::IDX_OUT_W-1:0] point_index_o,
  output logic        [fedp_pkg::DENS_W-1:0]    kinetic_o,
  output logic        [fedp_pkg::DENS_W-1:0]    gradient_o,
  output logic        [fedp_pkg::DENS_W-1:0]    potential_o,
  output logic        [fedp_pkg::DENS_W-1:0]    energy_density_o,
  output logic        [fedp_pkg::TOT_W-1:0]     total_energy_o,
  output logic        [fedp_pkg::TOT_W-1:0]     total_kinetic_o,
  output logic        [fedp_pkg::TOT_W-1:0]     total_gradient_o,
  output logic        [fedp_pkg::TOT_W-1:0]     total_potential_o,
  output logic        [fedp_pkg::TOT_W-1:0]     window_energy_o,
  output logic                                 final_result_o
);
  import fedp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  fedp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic, history and output register.
  fedp_dp #(
    .GRID_POINTS (GRID_POINTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .field_value_i     (field_value_i),
    .field_rate_i      (field_rate_i),
    .last_sample_i     (last_sample_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .point_index_o     (point_index_o),
    .kinetic_o         (kinetic_o),
    .gradient_o        (gradient_o),
    .potential_o       (potential_o),
    .energy_density_o  (energy_density_o),
    .total_energy_o    (total_energy_o),
    .total_kinetic_o   (total_kinetic_o),
    .total_gradient_o  (total_gradient_o),
    .total_potential_o (total_potential_o),
    .window_energy_o   (window_energy_o),
    .final_result_o    (final_result_o)
  );

endmodule

[tb/tb_field_energy_density_periodic.sv]
// Self-checking testbench of the streamed field energy density block on a periodic grid.
`timescale 1ns / 100ps

module tb_field_energy_density_periodic;
  import fedp_pkg::*;

  localparam int GRID_N      = 1024;
  localparam int VMIN        = -8388608;
  localparam int VMAX        = 8388607;
  localparam int SETTLE      = 60;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS    = 19;

  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;

  // One result of the block, field by field.
  typedef struct {
    bit [IDX_OUT_W-1:0] idx;
    bit [DENS_W-1:0]    kin;
    bit [DENS_W-1:0]    grad;
    bit [DENS_W-1:0]    pot;
    bit [DENS_W-1:0]    en;
    bit [TOT_W-1:0]     tot_en;
    bit [TOT_W-1:0]     tot_kin;
    bit [TOT_W-1:0]     tot_grad;
    bit [TOT_W-1:0]     tot_pot;
    bit [TOT_W-1:0]     win;
    bit                 fin;
  } density_t;

  // A directed sample. Rows marked typed are single-sample fields under the
  // reset settings, whose only result follows from the kinetic and potential
  // columns alone.
  typedef struct {
    int              value;
    int              rate;
    bit              last;
    bit              typed;
    longint unsigned kin;
    longint unsigned pot;
  } sample_row_t;

  sample_row_t directed_rows [DIR_ROWS] = '{
    '{0, 0, 1'b1, 1'b1, 0, 0},
    '{VMIN, VMIN, 1'b1, 1'b1, 536870912, 8388608},
    '{VMAX, VMAX, 1'b1, 1'b1, 536870784, 8388607},
    '{-1, 1, 1'b1, 1'b1, 0, 1},
    '{VMAX, 0, 1'b0, 1'b0, 0, 0},
    '{VMIN, VMAX, 1'b1, 1'b0, 0, 0},
    '{VMIN, 1, 1'b0, 1'b0, 0, 0},
    '{VMAX, -1, 1'b0, 1'b0, 0, 0},
    '{0, VMIN, 1'b1, 1'b0, 0, 0},
    '{VMAX, VMIN, 1'b0, 1'b0, 0, 0},
    '{VMIN, VMAX, 1'b0, 1'b0, 0, 0},
    '{VMAX, 0, 1'b0, 1'b0, 0, 0},
    '{VMIN, -1, 1'b0, 1'b0, 0, 0},
    '{1, VMAX, 1'b0, 1'b0, 0, 0},
    '{-1, VMIN, 1'b1, 1'b0, 0, 0},
    '{256, -256, 1'b0, 1'b0, 0, 0},
    '{-65536, 65536, 1'b0, 1'b0, 0, 0},
    '{65536, 131072, 1'b0, 1'b0, 0, 0},
    '{0, 0, 1'b1, 1'b0, 0, 0}
  };

  logic                        clk_i             = 1'b0;
  logic                        rst_ni            = 1'b0;
  logic                        cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index_i       = CFG_INV_TWO_H;
  logic [CFG_W-1:0]            cfg_data_i        = '0;
  logic                        in_valid_i        = 1'b0;
  logic                        in_stall_o;
  logic signed [VAL_W-1:0]     field_value_i     = '0;
  logic signed [VAL_W-1:0]     field_rate_i      = '0;
  logic                        last_sample_i     = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i       = 1'b0;
  logic [IDX_OUT_W-1:0]        point_index_o;
  logic [DENS_W-1:0]           kinetic_o;
  logic [DENS_W-1:0]           gradient_o;
  logic [DENS_W-1:0]           potential_o;
  logic [DENS_W-1:0]           energy_density_o;
  logic [TOT_W-1:0]            total_energy_o;
  logic [TOT_W-1:0]            total_kinetic_o;
  logic [TOT_W-1:0]            total_gradient_o;
  logic [TOT_W-1:0]            total_potential_o;
  logic [TOT_W-1:0]            window_energy_o;
  logic                        final_result_o;

  // Predictor state and its copy of the configuration registers.
  bit [CFG_W-1:0]  inv_two_h_copy = INV_TWO_H_RST;
  bit [CFG_W-1:0]  grid_step_copy = GRID_STEP_RST;
  bit [WIN_W-1:0]  window_lo_copy = WINDOW_LO_RST;
  bit [WIN_W-1:0]  window_hi_copy = WINDOW_HI_RST;
  int unsigned     sample_count;
  int              older_value, newer_value, newer_rate;
  int              first_value, second_value, first_rate;
  bit [TOT_W-1:0]  energy_sum, kinetic_sum, gradient_sum, potential_sum, window_sum;

  density_t pending_points[$];
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  int       gap_pct      = 0;
  int       stall_pct    = 0;
  int       hold_asked   = 0;
  int       hold_taken   = 0;
  int       hold_left    = 0;

  field_energy_density_periodic #(
    .GRID_POINTS(GRID_N)
  ) u_top (.*);

  always #5 clk_i = ~clk_i;

  // Magnitude of a signed value.
  function automatic longint unsigned mag(input longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // Running sum that sticks at the largest 48-bit value.
  function automatic bit [TOT_W-1:0] add_sat(input bit [TOT_W-1:0] a, input longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > MASK48) ? MASK48[TOT_W-1:0] : s[TOT_W-1:0];
  endfunction

  // A sum times the grid step, split so the product stays inside 64 bits.
  function automatic bit [TOT_W-1:0] scaled_total(input bit [TOT_W-1:0] s);
    longint unsigned hi, lo, t;
    hi = s >> 24;
    lo = s & 64'hFF_FFFF;
    t = ((hi * grid_step_copy) << 8) + ((lo * grid_step_copy) >> 16);
    return (t > MASK48) ? MASK48[TOT_W-1:0] : t[TOT_W-1:0];
  endfunction

  // Densities of one point from its neighbors; the sums take it in as well.
  function automatic density_t density_point(input int unsigned idx, input int left,
                                             input int centre, input int right,
                                             input int rate);
    density_t        p;
    longint unsigned ar, kin, slope, grad, pot, en;
    p = '{default: 0};
    ar = mag(rate);
    kin = (ar * ar) >> 17;
    slope = (mag(longint'(right) - longint'(left)) * inv_two_h_copy) >> 16;
    grad = (slope * slope) >> 17;
    if (grad > MASK32) begin
      grad = MASK32;
    end
    pot = mag(centre);
    en = kin + grad + pot;
    if (en > MASK32) begin
      en = MASK32;
    end
    p.idx  = idx[IDX_OUT_W-1:0];
    p.kin  = kin[DENS_W-1:0];
    p.grad = grad[DENS_W-1:0];
    p.pot  = pot[DENS_W-1:0];
    p.en   = en[DENS_W-1:0];
    kinetic_sum   = add_sat(kinetic_sum, kin);
    gradient_sum  = add_sat(gradient_sum, grad);
    potential_sum = add_sat(potential_sum, pot);
    energy_sum    = add_sat(energy_sum, en);
    if (idx >= window_lo_copy && idx < window_hi_copy) begin
      window_sum = add_sat(window_sum, en);
    end
    return p;
  endfunction

  // Takes one sample into the field and gives the points it completes.
  function automatic void advance_field(input int v, input int r, input bit last_in,
                                        output density_t pts[$]);
    int unsigned c;
    bit          closing;
    density_t    tail;
    c = sample_count;
    closing = last_in || (c >= GRID_N - 1);
    pts = {};
    if (c == 0) begin
      first_value  = v;
      second_value = v;
      first_rate   = r;
    end else if (c == 1) begin
      second_value = v;
    end
    if (c >= 2) begin
      pts.push_back(density_point(c - 1, older_value, newer_value, v, newer_rate));
    end
    if (closing) begin
      pts.push_back(density_point(c, (c >= 1) ? newer_value : v, v, first_value, r));
      if (c >= 1) begin
        pts.push_back(density_point(0, v, first_value, second_value, first_rate));
      end
      tail = pts[pts.size() - 1];
      tail.tot_en   = scaled_total(energy_sum);
      tail.tot_kin  = scaled_total(kinetic_sum);
      tail.tot_grad = scaled_total(gradient_sum);
      tail.tot_pot  = scaled_total(potential_sum);
      tail.win      = scaled_total(window_sum);
      tail.fin      = 1'b1;
      pts[pts.size() - 1] = tail;
      sample_count  = 0;
      energy_sum    = '0;
      kinetic_sum   = '0;
      gradient_sum  = '0;
      potential_sum = '0;
      window_sum    = '0;
    end else begin
      older_value  = newer_value;
      newer_value  = v;
      newer_rate   = r;
      sample_count = c + 1;
    end
  endfunction

  // A random sample value, weighted toward the extremes and small values.
  function automatic logic signed [VAL_W-1:0] random_sample();
    logic [VAL_W-1:0] raw;
    raw = VAL_W'($urandom);
    case ($urandom_range(9))
      0: raw = VAL_W'(VMIN);
      1: raw = VAL_W'(VMAX);
      2: raw = '0;
      3, 4: raw = VAL_W'($urandom_range(0, 512) - 256);
      default: ;
    endcase
    return raw;
  endfunction

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offers one sample after an optional idle gap and predicts once it is taken.
  task automatic drive_sample(input logic signed [VAL_W-1:0] v,
                              input logic signed [VAL_W-1:0] r, input bit last,
                              output density_t pts[$]);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < gap_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    field_value_i <= v;
    field_rate_i  <= r;
    last_sample_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    advance_field(v, r, last, pts);
  endtask

  // Stops offering and waits for every predicted result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_points.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_INV_TWO_H: inv_two_h_copy = data;
      CFG_GRID_STEP: grid_step_copy = data;
      CFG_WINDOW_LO: window_lo_copy = data[WIN_W-1:0];
      CFG_WINDOW_HI: window_hi_copy = data[WIN_W-1:0];
      default: ;
    endcase
  endtask

  // Waits out the block's own latency, then writes all four registers.
  task automatic reconfigure(input logic [CFG_W-1:0] inv, input logic [CFG_W-1:0] step,
                             input int lo, input int hi);
    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    write_reg(CFG_INV_TWO_H, inv);
    write_reg(CFG_GRID_STEP, step);
    write_reg(CFG_WINDOW_LO, CFG_W'(lo));
    write_reg(CFG_WINDOW_HI, CFG_W'(hi));
    cfg_we_i <= 1'b0;
  endtask

  // Whole fields of random length with random content.
  task automatic run_fields(input int n_items, input bit pause_between);
    density_t pts[$];
    int       sent, len, k;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: len = 1;
        1: len = 2;
        2: len = 3;
        default: len = $urandom_range(4, 24);
      endcase
      for (k = 0; k < len; k++) begin
        drive_sample(random_sample(), random_sample(), k == len - 1, pts);
        foreach (pts[j]) pending_points.push_back(pts[j]);
      end
      sent += len;
      if (pause_between && $urandom_range(7) == 0) begin
        drain_results();
      end
    end
  endtask

  // Receiver: random stall, or a long hold-off when one is asked for.
  always @(posedge clk_i) begin
    if (hold_asked != hold_taken) begin
      hold_taken  <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checking and the watchdog on handshakes.
  always @(posedge clk_i) begin : check_results
    density_t got, want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("field_energy_density_periodic: mismatch");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        got.idx      = point_index_o;
        got.kin      = kinetic_o;
        got.grad     = gradient_o;
        got.pot      = potential_o;
        got.en       = energy_density_o;
        got.tot_en   = total_energy_o;
        got.tot_kin  = total_kinetic_o;
        got.tot_grad = total_gradient_o;
        got.tot_pot  = total_potential_o;
        got.win      = window_energy_o;
        got.fin      = final_result_o;
        if (pending_points.size() == 0) begin
          $error("result for point %0d with no request pending", got.idx);
          mismatches++;
        end else begin
          want = pending_points.pop_front();
          compare_field("point_index", want.idx, got.idx);
          compare_field("kinetic", want.kin, got.kin);
          compare_field("gradient", want.grad, got.grad);
          compare_field("potential", want.pot, got.pot);
          compare_field("energy_density", want.en, got.en);
          compare_field("total_energy", want.tot_en, got.tot_en);
          compare_field("total_kinetic", want.tot_kin, got.tot_kin);
          compare_field("total_gradient", want.tot_grad, got.tot_grad);
          compare_field("total_potential", want.tot_pot, got.tot_pot);
          compare_field("window_energy", want.win, got.win);
          compare_field("final_result", want.fin, got.fin);
        end
      end
    end
  end

  initial begin : stimulus
    density_t pts[$];
    density_t typed_point;
    int       i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows under the reset settings, with no idling.
    for (i = 0; i < DIR_ROWS; i++) begin
      drive_sample(VAL_W'(directed_rows[i].value), VAL_W'(directed_rows[i].rate),
                   directed_rows[i].last, pts);
      if (directed_rows[i].typed) begin
        typed_point          = '{default: 0};
        typed_point.kin      = DENS_W'(directed_rows[i].kin);
        typed_point.pot      = DENS_W'(directed_rows[i].pot);
        typed_point.en       = DENS_W'(directed_rows[i].kin + directed_rows[i].pot);
        typed_point.tot_en   = TOT_W'(directed_rows[i].kin + directed_rows[i].pot);
        typed_point.tot_kin  = TOT_W'(directed_rows[i].kin);
        typed_point.tot_pot  = TOT_W'(directed_rows[i].pot);
        typed_point.win      = TOT_W'(directed_rows[i].kin + directed_rows[i].pot);
        typed_point.fin      = 1'b1;
        pending_points.push_back(typed_point);
      end else begin
        foreach (pts[j]) pending_points.push_back(pts[j]);
      end
    end

    // Random settings, idle sender.
    reconfigure(CFG_W'($urandom), CFG_W'($urandom), $urandom_range(0, 1024),
                $urandom_range(0, 1024));
    gap_pct = 67;
    stall_pct = 0;
    run_fields(55, 1'b0);

    // Largest scale factors saturate the gradient, the energy and the totals.
    // A long hold-off at the start lets the block fill and stall its input.
    reconfigure(24'hFF_FFFF, 24'hFF_FFFF, 0, 1024);
    gap_pct = 0;
    stall_pct = 67;
    hold_asked++;
    run_fields(55, 1'b0);

    // Zero scale factors and an empty window.
    reconfigure(24'd0, 24'd0, 1024, 0);
    gap_pct = 31;
    stall_pct = 31;
    run_fields(55, 1'b0);

    // A narrow window over the low indexes, with no idling.
    reconfigure(CFG_W'($urandom_range(0, 24'h3_FFFF)), GRID_STEP_RST, 2, 9);
    gap_pct = 0;
    stall_pct = 0;
    run_fields(30, 1'b0);

    // Random settings again, both sides idling, with pauses between fields.
    reconfigure(CFG_W'($urandom), CFG_W'($urandom), $urandom_range(0, 20),
                $urandom_range(0, 30));
    gap_pct = 31;
    stall_pct = 31;
    run_fields(55, 1'b1);

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("field_energy_density_periodic: match");
    end else begin
      $display("field_energy_density_periodic: mismatch");
    end
    $finish;
  end

endmodule
